// ===== rtl/core/peak_normalize_mirror_buffer_macros.svh =====
// ----------------------------------------------------------------------------
// peak_normalize_mirror_buffer_macros
// assertion helpers shared by the peak normalize mirror buffer rtl
// ----------------------------------------------------------------------------
`ifndef PEAK_NORMALIZE_MIRROR_BUFFER_MACROS_SVH
`define PEAK_NORMALIZE_MIRROR_BUFFER_MACROS_SVH

// same-cycle implication, reset masks the check
`define PNMB_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pnmb assertion failed");

// next-cycle implication, reset masks the check
`define PNMB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pnmb assertion failed");

`endif

// ===== rtl/core/pnmb_pkg.sv =====
// ----------------------------------------------------------------------------
// pnmb_pkg
// shared constants and types of the peak normalize mirror buffer
// ----------------------------------------------------------------------------
package pnmb_pkg;

    localparam int BUFFER_SIZE_DEF = 1024;

    localparam int SAMPLE_W   = 16;
    localparam int INDEX_W    = 11;
    localparam int CMD_W      = 2;
    localparam int DIVIDEND_W = 30;
    localparam int QUOT_W     = 15;

    localparam logic [CMD_W-1:0] CMD_PUSH = 2'd0;
    localparam logic [CMD_W-1:0] CMD_END  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ = 2'd2;

    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [SAMPLE_W-1:0]   divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [QUOT_W-1:0] quotient;
    } div_rsp_t;

endpackage

// ===== rtl/core/peak_normalize_mirror_buffer.sv =====
// ----------------------------------------------------------------------------
// peak_normalize_mirror_buffer
// frame store with peak tracking and normalized palindrome read-back
//
// one command word is taken at a clock edge with start high and busy low.
// push and end of frame finish in that cycle and never raise busy.
// a read in the mirrored range raises busy; its word appears on value with
// done high for exactly one cycle, after two store reads, the average, the
// scale stage and the 15-step divider with its overflow check (no divide for
// a zero frame peak, no steps when the quotient saturates). a read past the
// mirrored range leaves busy low and returns zero with done high. busy falls
// in the same cycle done is high, so a read finishes before the next command.
// the receiver takes done words as they come and cannot stall the block.
// reset clears counts and peaks; the sample store keeps old contents and
// needs no clearing pass, since reads only reach written entries.
// ----------------------------------------------------------------------------
`include "peak_normalize_mirror_buffer_macros.svh"

module peak_normalize_mirror_buffer #(
    parameter int BUFFER_SIZE = pnmb_pkg::BUFFER_SIZE_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [pnmb_pkg::CMD_W-1:0]           cmd,
    input  logic signed [pnmb_pkg::SAMPLE_W-1:0] sample,
    input  logic [pnmb_pkg::INDEX_W-1:0]         index,
    output logic signed [pnmb_pkg::SAMPLE_W-1:0] value,
    output logic                                 done
);
    import pnmb_pkg::*;

    // count holds 0..N, store address 0..N-1, index math wide enough for 2N
    localparam int CW = $clog2(BUFFER_SIZE + 1);
    localparam int AW = $clog2(BUFFER_SIZE);
    localparam int XW = (CW + 1 > INDEX_W) ? CW + 1 : INDEX_W;

    localparam logic [XW-1:0] N_X    = XW'(BUFFER_SIZE);
    localparam logic [XW-1:0] N2_X   = XW'(2 * BUFFER_SIZE);
    localparam logic [XW-1:0] LAST_X = XW'(BUFFER_SIZE - 1);
    localparam logic [XW-1:0] MIR_X  = XW'(2 * BUFFER_SIZE - 1);
    localparam logic [AW-1:0] LAST_A = AW'(BUFFER_SIZE - 1);
    localparam logic [CW-1:0] N_C    = CW'(BUFFER_SIZE);

    localparam logic signed [SAMPLE_W-1:0] NEG_SAT = -16'sd32767;
    localparam logic signed [SAMPLE_W-1:0] MOST_NEG = 16'sh8000;

    // sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD0  = 3'd1;
    localparam logic [2:0] S_RD1  = 3'd2;
    localparam logic [2:0] S_AVG  = 3'd3;
    localparam logic [2:0] S_MUL  = 3'd4;
    localparam logic [2:0] S_DIV  = 3'd5;

    logic [2:0]                  state_reg, state_next;
    logic [CW-1:0]               write_count_reg, write_count_next;
    logic [SAMPLE_W-1:0]         running_peak_reg, running_peak_next;
    logic [CW-1:0]               frame_count_reg, frame_count_next;
    logic [SAMPLE_W-1:0]         frame_peak_reg, frame_peak_next;
    logic                        done_reg, done_next;
    logic signed [SAMPLE_W-1:0]  value_reg, value_next;

    // per-read working registers
    logic [AW-1:0]               pos_reg, pos_next;
    logic                        join_reg, join_next;
    logic                        ok_first_reg, ok_first_next;
    logic                        ok_last_reg, ok_last_next;
    logic signed [SAMPLE_W-1:0]  acc_reg, acc_next;
    logic signed [SAMPLE_W-1:0]  raw_reg, raw_next;
    logic                        neg_reg, neg_next;

    // sample store
    logic signed [SAMPLE_W-1:0]  store_mem [BUFFER_SIZE];
    logic signed [SAMPLE_W-1:0]  rd_q_reg;
    logic [AW-1:0]               rd_addr;

    logic                        accept;
    logic                        push_ok;
    logic                        push_we;
    logic [SAMPLE_W-1:0]         sample_mag;
    logic [XW-1:0]               idx_x;
    logic [XW-1:0]               pos_x;
    logic                        rd_oor;
    logic                        rd_join;
    logic signed [SAMPLE_W-1:0]  second;
    logic signed [SAMPLE_W:0]    pair_sum;
    logic [SAMPLE_W-1:0]         raw_mag;
    logic [DIVIDEND_W:0]         mag_x;
    logic [DIVIDEND_W:0]         scaled;
    logic signed [SAMPLE_W-1:0]  quot_s;

    div_req_t                    div_req;
    div_rsp_t                    div_rsp;

    assign accept  = start && !busy;
    assign push_ok = write_count_reg < N_C;
    assign push_we = accept && (cmd == CMD_PUSH) && push_ok;

    // magnitude of a push sample, the most negative code maps to 0x8000
    assign sample_mag = sample[SAMPLE_W-1] ? (16'd0 - sample) : sample;

    // extended index to store position, join entries and range
    assign idx_x   = XW'(index);
    assign rd_oor  = idx_x >= N2_X;
    assign rd_join = (idx_x == LAST_X) || (idx_x == N_X);
    assign pos_x   = (idx_x < N_X) ? idx_x : (MIR_X - idx_x);

    // second operand of the join average, zero past the latched count
    assign second   = ok_last_reg ? rd_q_reg : '0;
    assign pair_sum = {acc_reg[SAMPLE_W-1], acc_reg} + {second[SAMPLE_W-1], second};

    // |raw| * 32767 as a shift and subtract
    assign raw_mag = raw_reg[SAMPLE_W-1] ? (16'd0 - raw_reg) : raw_reg;
    assign mag_x   = (DIVIDEND_W + 1)'(raw_mag);
    assign scaled  = (mag_x << (SAMPLE_W - 1)) - mag_x;

    assign quot_s = {1'b0, div_rsp.quotient};

    always_comb
    begin
        unique case (state_reg)
            S_RD0:   rd_addr = join_reg ? '0 : pos_reg;
            default: rd_addr = LAST_A;
        endcase
    end

    always_comb
    begin
        div_req.start    = 1'b0;
        div_req.dividend = scaled[DIVIDEND_W-1:0];
        div_req.divisor  = frame_peak_reg;

        state_next        = state_reg;
        write_count_next  = write_count_reg;
        running_peak_next = running_peak_reg;
        frame_count_next  = frame_count_reg;
        frame_peak_next   = frame_peak_reg;
        done_next         = 1'b0;
        value_next        = value_reg;
        pos_next          = pos_reg;
        join_next         = join_reg;
        ok_first_next     = ok_first_reg;
        ok_last_next      = ok_last_reg;
        acc_next          = acc_reg;
        raw_next          = raw_reg;
        neg_next          = neg_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (cmd)
                        CMD_PUSH:
                        begin
                            // full frame drops the sample entirely
                            if (push_ok)
                            begin
                                write_count_next = write_count_reg + 1'b1;
                                if (sample_mag > running_peak_reg)
                                begin
                                    running_peak_next = sample_mag;
                                end
                            end
                        end
                        CMD_END:
                        begin
                            frame_count_next  = write_count_reg;
                            frame_peak_next   = running_peak_reg;
                            write_count_next  = '0;
                            running_peak_next = '0;
                        end
                        CMD_READ:
                        begin
                            if (rd_oor)
                            begin
                                value_next = '0;
                                done_next  = 1'b1;
                            end
                            else
                            begin
                                pos_next      = pos_x[AW-1:0];
                                join_next     = rd_join;
                                // join reads first sample, else the mapped position
                                ok_first_next = rd_join ? (frame_count_reg != '0)
                                                        : (pos_x < XW'(frame_count_reg));
                                ok_last_next  = frame_count_reg == N_C;
                                state_next    = S_RD0;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_RD0:
            begin
                state_next = S_RD1;
            end
            S_RD1:
            begin
                acc_next   = ok_first_reg ? rd_q_reg : '0;
                state_next = S_AVG;
            end
            S_AVG:
            begin
                // floor average of first and last sample at the join
                raw_next   = join_reg ? pair_sum[SAMPLE_W:1] : acc_reg;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                if (frame_peak_reg == '0)
                begin
                    value_next = (raw_reg == MOST_NEG) ? NEG_SAT : raw_reg;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    neg_next      = raw_reg[SAMPLE_W-1];
                    div_req.start = 1'b1;
                    state_next    = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_rsp.done)
                begin
                    // truncation toward zero: divide magnitude, restore sign
                    value_next = neg_reg ? (16'sd0 - quot_s) : quot_s;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    pnmb_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            write_count_reg  <= '0;
            running_peak_reg <= '0;
            frame_count_reg  <= '0;
            frame_peak_reg   <= '0;
            done_reg         <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            write_count_reg  <= write_count_next;
            running_peak_reg <= running_peak_next;
            frame_count_reg  <= frame_count_next;
            frame_peak_reg   <= frame_peak_next;
            done_reg         <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg    <= value_next;
        pos_reg      <= pos_next;
        join_reg     <= join_next;
        ok_first_reg <= ok_first_next;
        ok_last_reg  <= ok_last_next;
        acc_reg      <= acc_next;
        raw_reg      <= raw_next;
        neg_reg      <= neg_next;
    end

    // store: one write port for pushes, one registered read port
    always_ff @(posedge clk)
    begin
        if (push_we)
        begin
            store_mem[write_count_reg[AW-1:0]] <= sample;
        end
        rd_q_reg <= store_mem[rd_addr];
    end

    assign busy  = state_reg != S_IDLE;
    assign done  = done_reg;
    assign value = value_reg;

    `PNMB_ASSERT_IMPLY(a_done_when_idle, clk, rst_n, done, !busy)
    `PNMB_ASSERT_IMPLY(a_count_bound, clk, rst_n, 1'b1, write_count_reg <= N_C)
    `PNMB_ASSERT_NEXT(a_div_gives_word, clk, rst_n, (state_reg == S_DIV) && div_rsp.done, done)
    `PNMB_ASSERT_IMPLY(a_value_saturated, clk, rst_n, done, value != MOST_NEG)

endmodule

// ===== rtl/core/pnmb_div.sv =====
// ----------------------------------------------------------------------------
// pnmb_div
// restoring divider, one quotient bit per cycle, saturating at 15 bits
// ----------------------------------------------------------------------------
module pnmb_div (
    input  logic                clk,
    input  logic                rst_n,
    input  pnmb_pkg::div_req_t  req,
    output pnmb_pkg::div_rsp_t  rsp
);
    import pnmb_pkg::*;

    localparam logic [1:0] D_IDLE = 2'd0;
    localparam logic [1:0] D_CHK  = 2'd1;
    localparam logic [1:0] D_RUN  = 2'd2;

    localparam int CNT_W = $clog2(QUOT_W);
    localparam int LOW_W = DIVIDEND_W - QUOT_W;

    logic [1:0]            state_reg, state_next;
    logic [DIVIDEND_W-1:0] dvd_reg, dvd_next;
    logic [SAMPLE_W-1:0]   dsr_reg, dsr_next;
    logic [SAMPLE_W-1:0]   rem_reg, rem_next;
    logic [QUOT_W-1:0]     quo_reg, quo_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  done_reg, done_next;

    logic [SAMPLE_W:0]     sub_a;
    logic [SAMPLE_W+1:0]   diff;
    logic                  ge;

    // the one shared subtractor: overflow check first, then one bit a cycle
    always_comb
    begin
        if (state_reg == D_CHK)
        begin
            sub_a = (SAMPLE_W + 1)'(dvd_reg[DIVIDEND_W-1:LOW_W]);
        end
        else
        begin
            sub_a = {rem_reg, dvd_reg[LOW_W-1]};
        end
        diff = {1'b0, sub_a} - {2'b00, dsr_reg};
        ge   = !diff[SAMPLE_W+1];
    end

    always_comb
    begin
        state_next = state_reg;
        dvd_next   = dvd_reg;
        dsr_next   = dsr_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            D_IDLE:
            begin
                if (req.start)
                begin
                    dvd_next   = req.dividend;
                    dsr_next   = req.divisor;
                    state_next = D_CHK;
                end
            end
            D_CHK:
            begin
                if (ge)
                begin
                    // quotient would need 16 bits or more: saturate
                    quo_next   = '1;
                    done_next  = 1'b1;
                    state_next = D_IDLE;
                end
                else
                begin
                    rem_next   = sub_a[SAMPLE_W-1:0];
                    cnt_next   = CNT_W'(QUOT_W - 1);
                    state_next = D_RUN;
                end
            end
            D_RUN:
            begin
                rem_next = ge ? diff[SAMPLE_W-1:0] : sub_a[SAMPLE_W-1:0];
                quo_next = {quo_reg[QUOT_W-2:0], ge};
                dvd_next = dvd_reg << 1;
                if (cnt_reg == '0)
                begin
                    done_next  = 1'b1;
                    state_next = D_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            default:
            begin
                state_next = D_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule
